// ===== sv/susset_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// susset_pkg
// Shared types and constants for the sorted unique symbol set.
// ----------------------------------------------------------------------------
package susset_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OUT_N_W  = 7;

    typedef logic [SYM_W-1:0]    sym_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_INSERTED = 2'd0;
    localparam status_t ST_PRESENT  = 2'd1;
    localparam status_t ST_FULL     = 2'd2;

    // Compare flags that one cell hands to its right neighbor and to the encoder
    typedef struct packed {
        logic lt;   // held entry is below the offered symbol
        logic eq;   // held entry matches the offered symbol
        logic hit;  // first cell whose entry is not below the symbol
    } cell_flags_t;

endpackage

// ===== sv/susset_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// susset_cell
// One slot of the sorted chain: compares against the offered symbol and,
// on insert, keeps its entry, takes the symbol, or takes its left neighbor.
// ----------------------------------------------------------------------------
module susset_cell
    import susset_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sym_t        sym,
    input  logic        cmp_en,
    input  logic        ins_en,
    input  sym_t        left_entry,
    input  logic        left_lt,
    output sym_t        entry,
    output cell_flags_t flags
);

    sym_t entry_reg;
    sym_t entry_next;
    logic lt_reg;
    logic lt_next;
    logic eq_reg;
    logic eq_next;

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        entry_next = entry_reg;
        if (cmp_en)
        begin
            // Zero marks an empty slot and never compares as held
            lt_next = (entry_reg != '0) && (entry_reg < sym);
            eq_next = (entry_reg != '0) && (entry_reg == sym);
        end
        if (ins_en && !lt_reg)
        begin
            entry_next = left_lt ? sym : left_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    assign entry     = entry_reg;
    assign flags.lt  = lt_reg;
    assign flags.eq  = eq_reg;
    assign flags.hit = !lt_reg && left_lt;

endmodule

// ===== sv/susset_enc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// susset_enc
// Gathers the cell flags: match detect and index of the insertion point.
// ----------------------------------------------------------------------------
module susset_enc
    import susset_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
)
(
    input  cell_flags_t      flags [CAPACITY],
    output logic             present,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    always_comb
    begin
        present = 1'b0;
        found   = 1'b0;
        idx     = '0;
        // The hit flags are one-hot over a sorted chain, so OR the indexes
        for (int i = 0; i < CAPACITY; i++)
        begin
            present = present | flags[i].eq;
            found   = found | flags[i].hit;
            idx     = idx | (flags[i].hit ? IDX_W'(i) : '0);
        end
    end

endmodule

// ===== sv/sorted_unique_symbol_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_symbol_set
// Sorted set of distinct non-zero byte symbols held in a chain of cells.
// ----------------------------------------------------------------------------
// Each slave transfer offers one symbol and yields exactly one master
// transfer with status (inserted, present, or full and dropped), the sorted
// position and the entry count after the step. Symbol zero is reserved and
// reports present at the current count. The symbol is latched at the
// accepting edge; then every cell compares it against its entry, the
// insertion point is encoded across the chain and registered, and the
// chain shifts as the output register is loaded. The next symbol is
// accepted in the cycle after that, even if that result has not been
// taken yet; no symbol is taken while one is in flight. When a result is
// ready while the one before it still waits in the output register, hold
// the chain until that transfer. The set is empty after reset; no
// clearing pass is needed.
module sorted_unique_symbol_set
    import susset_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [8:2] position, [15:9] entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_DEC  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    sym_t             sym_reg;
    logic [CNT_W-1:0] cnt_reg;
    status_t          status_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] new_cnt_reg;
    logic             ins_reg;

    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [CNT_W-1:0] m_pos_reg;
    logic [CNT_W-1:0] m_cnt_reg;

    logic             accept;
    logic             out_free;
    logic             cmp_en;
    logic             ins_en;
    logic             load_out;

    sym_t             entries [CAPACITY];
    cell_flags_t      flags   [CAPACITY];
    logic             present;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic             full;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmp_en   = (state_reg == S_CMP);
    assign load_out = (state_reg == S_OUT) && out_free;
    assign ins_en   = load_out && ins_reg;
    assign full     = (cnt_reg == CNT_W'(CAPACITY));

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sym_t left_entry;
        logic left_lt;
        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_lt    = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = entries[i-1];
            assign left_lt    = flags[i-1].lt;
        end
        susset_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .sym        (sym_reg),
            .cmp_en     (cmp_en),
            .ins_en     (ins_en),
            .left_entry (left_entry),
            .left_lt    (left_lt),
            .entry      (entries[i]),
            .flags      (flags[i])
        );
    end

    susset_enc #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_enc (
        .flags   (flags),
        .present (present),
        .found   (found),
        .idx     (idx)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CMP;
            S_CMP:   state_next = S_DEC;
            S_DEC:   state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ins_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DEC)
            begin
                ins_reg <= (sym_reg != '0) && !present && !full;
            end
            if (load_out)
            begin
                cnt_reg     <= new_cnt_reg;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg <= s_tdata;
        end
        if (state_reg == S_DEC)
        begin
            if (sym_reg == '0)
            begin
                status_reg  <= ST_PRESENT;
                pos_reg     <= cnt_reg;
                new_cnt_reg <= cnt_reg;
            end
            else if (present)
            begin
                status_reg  <= ST_PRESENT;
                pos_reg     <= CNT_W'(idx);
                new_cnt_reg <= cnt_reg;
            end
            else if (full || !found)
            begin
                // Drop: report the count as position
                status_reg  <= ST_FULL;
                pos_reg     <= cnt_reg;
                new_cnt_reg <= cnt_reg;
            end
            else
            begin
                status_reg  <= ST_INSERTED;
                pos_reg     <= CNT_W'(idx);
                new_cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        if (load_out)
        begin
            m_status_reg <= status_reg;
            m_pos_reg    <= pos_reg;
            m_cnt_reg    <= new_cnt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {OUT_N_W'(m_cnt_reg), OUT_N_W'(m_pos_reg), m_status_reg};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && status_reg == ST_FULL |-> full && !ins_reg)
        else $error("symbol dropped while set not full");

    a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && status_reg == ST_INSERTED |-> pos_reg < new_cnt_reg)
        else $error("insert position beyond count");
`endif

endmodule

// ===== verif/sorted_unique_symbol_set_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_symbol_set_test
// Self-checking bench for the sorted unique symbol set.
// ----------------------------------------------------------------------------
// Symbols are pushed through the slave stream from a pending queue in bursts
// with random gaps. Every accepted symbol is applied to a local copy of the
// sorted set, which predicts the status, position and count that the master
// stream must return. The receiver stalls on its own pattern, once for a long
// stretch, so the block fills up and backs up its input.
// ----------------------------------------------------------------------------
module sorted_unique_symbol_set_test
    import susset_pkg::*;
();

    localparam int CAP        = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        status_t            status;
        logic [OUT_N_W-1:0] position;
        logic [OUT_N_W-1:0] entry_count;
    } set_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] symbol
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [1:0] status, [8:2] position, [15:9] entry_count

    sym_t        pending_symbols[$];
    set_result_t expected_results[$];
    sym_t        held_symbols[CAP];
    int unsigned held_count = 0;

    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_cycle = 0;
    logic [1:0]  rx_mode = 2'd0;
    int          hold_left = 0;
    logic        long_hold_done = 1'b0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          fails = 0;

    sorted_unique_symbol_set #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // Apply one symbol to the local set and queue the result it must produce
    task automatic add_to_symbol_set(input sym_t sym);
        set_result_t r;
        int unsigned slot;
        slot = 0;
        if (sym == '0)
        begin
            r.status      = ST_PRESENT;
            r.position    = OUT_N_W'(held_count);
            r.entry_count = OUT_N_W'(held_count);
        end
        else
        begin
            while (slot < held_count && held_symbols[slot] < sym)
                slot++;
            if (slot < held_count && held_symbols[slot] == sym)
            begin
                r.status   = ST_PRESENT;
                r.position = OUT_N_W'(slot);
            end
            else if (held_count >= CAP)
            begin
                r.status   = ST_FULL;
                r.position = OUT_N_W'(held_count);
            end
            else
            begin
                for (int k = held_count; k > slot; k--)
                    held_symbols[k] = held_symbols[k-1];
                held_symbols[slot] = sym;
                held_count++;
                r.status   = ST_INSERTED;
                r.position = OUT_N_W'(slot);
            end
            r.entry_count = OUT_N_W'(held_count);
        end
        expected_results.push_back(r);
    endtask

    // Mostly fresh symbols, some already held, a few reserved zeros
    task automatic queue_random_symbols(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                pending_symbols.push_back('0);
            else if (pick < 30 && held_count != 0)
                pending_symbols.push_back(held_symbols[$urandom_range(0, held_count - 1)]);
            else
                pending_symbols.push_back(sym_t'($urandom_range(1, 255)));
        end
    endtask

    task automatic wait_drained;
        while (pending_symbols.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: hold the current transfer until taken, then offer the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                add_to_symbol_set(s_tdata);
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_symbols.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_symbols.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern redrawn at regular points of rx_cycle, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0)
                rx_mode <= 2'($urandom_range(0, 3));
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 500)
            begin
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD;
                m_tready       <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= 1'($urandom_range(0, 1));
                    2'd2: m_tready <= (rx_cycle % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer, m_tdata = %h", m_tdata);
                fails++;
            end
            else
            begin
                if (m_tdata[1:0] != expected_results[0].status)
                begin
                    $error("status: expected %0d, actual %0d",
                           expected_results[0].status, m_tdata[1:0]);
                    fails++;
                end
                if (m_tdata[8:2] != expected_results[0].position)
                begin
                    $error("position: expected %0d, actual %0d",
                           expected_results[0].position, m_tdata[8:2]);
                    fails++;
                end
                if (m_tdata[15:9] != expected_results[0].entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           expected_results[0].entry_count, m_tdata[15:9]);
                    fails++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        // Zero on empty set, extremes, duplicates at both ends, mid inserts
        pending_symbols = '{8'h00, 8'h01, 8'hFF, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h81,
                            8'h80, 8'h55, 8'hAA, 8'h02, 8'hFE, 8'h00, 8'h0F, 8'hF0,
                            8'h7F, 8'h40, 8'hC0, 8'h55};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();
        queue_random_symbols(600);
        // Pause the sender until every result is back
        wait_drained();
        queue_random_symbols(650);
        wait_drained();
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/susset_pkg.sv
sv/susset_cell.sv
sv/susset_enc.sv
sv/sorted_unique_symbol_set.sv
verif/sorted_unique_symbol_set_test.sv
